// ===== rtl/gec_pkg.sv =====
package gec_pkg;

  // Array geometry
  localparam int MaxRows = 4;
  localparam int MaxCols = 16;
  localparam int MaxLen  = 2048;

  localparam int ColW = $clog2(MaxCols);
  localparam int PosW = $clog2(MaxLen);

  // Work queue between front and back; depth is a power of two
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Register file
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_FIELD_POLY  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ROWS_IN_USE = 1'b1;

  localparam logic [7:0] FieldPolyReset = 8'd29;
  localparam logic [2:0] RowsInUseReset = 3'd4;

  // Opcodes on the input channel
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_DATA = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_DATA,
    KIND_READ
  } kind_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  row_index;
    logic [3:0]  packet_index;
    logic [10:0] byte_position;
    logic [7:0]  byte_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  out_row;
    logic [10:0] out_position;
    logic [7:0]  out_value;
  } out_beat_t;

  typedef struct packed {
    kind_e               kind;
    logic [MaxRows-1:0]  row_en;
    logic [1:0]          row;
    logic [ColW-1:0]     pkt;
    logic [PosW-1:0]     pos;
    logic [7:0]          val;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } queue_head_t;

  // GF(256) product reduced by x^8 + poly
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b, logic [7:0] poly);
    logic [7:0] prod;
    logic [7:0] aa;
    logic       carry;
    prod = 8'd0;
    aa   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        prod = prod ^ aa;
      end
      carry = aa[7];
      aa    = {aa[6:0], 1'b0};
      if (carry) begin
        aa = aa ^ poly;
      end
    end
    return prod;
  endfunction

endpackage

// ===== rtl/gec_front.sv =====
module gec_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gec_pkg::in_beat_t   in_data_i,
  input  logic [2:0]          rows_in_use_i,
  input  logic                pop_i,
  output gec_pkg::queue_head_t head_o
);

  gec_pkg::work_t              work;
  logic                        keep;
  logic [2:0]                  active;
  logic                        push;
  logic                        full;

  gec_pkg::work_t              fifo_q [gec_pkg::QDepth];
  logic [gec_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [gec_pkg::QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [gec_pkg::QCntW-1:0]   count_q, count_d;

  // Classify the beat; the unused opcode is dropped here
  always_comb begin
    active = (rows_in_use_i > 3'(gec_pkg::MaxRows)) ? 3'(gec_pkg::MaxRows) : rows_in_use_i;
    work.row_en = '0;
    for (int r = 0; r < gec_pkg::MaxRows; r++) begin
      work.row_en[r] = (active > 3'(r));
    end
    work.row = in_data_i.row_index;
    work.pkt = in_data_i.packet_index;
    work.pos = in_data_i.byte_position;
    work.val = in_data_i.byte_value;
    keep     = 1'b1;
    case (in_data_i.opcode)
      gec_pkg::OP_LOAD: work.kind = gec_pkg::KIND_LOAD;
      gec_pkg::OP_DATA: work.kind = gec_pkg::KIND_DATA;
      gec_pkg::OP_READ: work.kind = gec_pkg::KIND_READ;
      default: begin
        work.kind = gec_pkg::KIND_LOAD;
        keep      = 1'b0;
      end
    endcase
  end

  assign full       = (count_q == gec_pkg::QCntW'(gec_pkg::QDepth));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full && keep;

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= work;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.work  = fifo_q[rd_ptr_q];

endmodule

// ===== rtl/gec_back.sv =====
module gec_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gec_pkg::queue_head_t head_i,
  output logic                 pop_o,
  input  logic [7:0]           field_poly_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gec_pkg::out_beat_t   out_data_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  typedef logic [gec_pkg::MaxRows-1:0][7:0] word_t;

  logic                      state_q, state_d;
  gec_pkg::work_t            cur_q;
  logic                      clr_q;
  logic [gec_pkg::PosW-1:0]  clr_addr_q;

  word_t                     coef_mem [gec_pkg::MaxCols];
  word_t                     coef_rd_q;
  word_t                     acc_mem [gec_pkg::MaxLen];
  word_t                     acc_rd_q;

  logic                      coef_we;
  logic                      out_free;
  logic                      done;
  logic                      acc_we;
  logic [gec_pkg::PosW-1:0]  acc_waddr;
  word_t                     acc_wdata;
  word_t                     exec_word;
  logic                      out_load;

  logic                      out_valid_q;
  gec_pkg::out_beat_t        out_data_q;

  // Hold new work until the clearing pass is over
  assign pop_o   = (state_q == ST_IDLE) && !clr_q && head_i.valid;
  assign coef_we = pop_o && (head_i.work.kind == gec_pkg::KIND_LOAD);

  assign out_free = !out_valid_q || !out_stall_i;
  assign done     = (state_q == ST_EXEC) &&
                    ((cur_q.kind == gec_pkg::KIND_DATA) || out_free);
  assign out_load = done && (cur_q.kind == gec_pkg::KIND_READ);

  // Read-modify-write word: one GF multiplier lane per row; a read clears its row's byte
  always_comb begin
    exec_word = acc_rd_q;
    for (int r = 0; r < gec_pkg::MaxRows; r++) begin
      if (cur_q.kind == gec_pkg::KIND_READ) begin
        if (cur_q.row == 2'(r)) begin
          exec_word[r] = 8'd0;
        end
      end else if (cur_q.row_en[r]) begin
        exec_word[r] = acc_rd_q[r] ^ gec_pkg::gf_mul(coef_rd_q[r], cur_q.val, field_poly_i);
      end
    end
  end

  always_comb begin
    acc_we    = clr_q || done;
    acc_waddr = clr_q ? clr_addr_q : cur_q.pos;
    acc_wdata = clr_q ? '0 : exec_word;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o && (head_i.work.kind != gec_pkg::KIND_LOAD)) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == gec_pkg::PosW'(gec_pkg::MaxLen - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i.work;
    end
    if (out_load) begin
      out_data_q.out_row      <= cur_q.row;
      out_data_q.out_position <= cur_q.pos;
      out_data_q.out_value    <= acc_rd_q[cur_q.row];
    end
  end

  // Coefficient store: one word per source packet, a byte per row
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[head_i.work.pkt][head_i.work.row] <= head_i.work.val;
    end
    if (pop_o) begin
      coef_rd_q <= coef_mem[head_i.work.pkt];
    end
  end

  // Accumulator store: one word per byte position, a byte per row
  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (pop_o) begin
      acc_rd_q <= acc_mem[head_i.work.pos];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/gf256_erasure_code_mac.sv =====
// Channel   Direction  Handshake            Beat
// in        input      in_valid_i/in_stall_o    gec_pkg::in_beat_t (opcode, row, packet, pos, value)
// out       output     out_valid_o/out_stall_i  gec_pkg::out_beat_t (row, position, value)
// cfg       input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// A load is written to the coefficient store as it is popped; a data byte or
// a read does a read-modify-write of the accumulator word (registered read,
// then GF multiply and write back). Opcode 3 is accepted and dropped in the front.
// After reset the back end clears all 2048 words of the accumulator store, one
// word per cycle; input beats queue up meanwhile and cfg writes are taken.
// A read waits in the back end while the output register is full and stalled;
// the two-entry queue keeps the input side moving until it fills.
module gf256_erasure_code_mac (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  gec_pkg::in_beat_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output gec_pkg::out_beat_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gec_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [7:0]                      cfg_data_i
);

  logic [7:0]           field_poly_q;
  logic [2:0]           rows_in_use_q;
  logic                 cfg_we;
  gec_pkg::queue_head_t head;
  logic                 pop;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_poly_q  <= gec_pkg::FieldPolyReset;
      rows_in_use_q <= gec_pkg::RowsInUseReset;
    end else if (cfg_we) begin
      case (cfg_index_i)
        gec_pkg::CFG_FIELD_POLY:  field_poly_q  <= cfg_data_i;
        gec_pkg::CFG_ROWS_IN_USE: rows_in_use_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Front: classify beats, compute the active row mask, queue the work
  gec_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .rows_in_use_i (rows_in_use_q),
    .pop_i         (pop),
    .head_o        (head)
  );

  // Back: coefficient and accumulator stores, multiplier lanes, output register
  gec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .field_poly_i (field_poly_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
